// File: rtl/core/apc_pkg.sv
// Shared types, codes and rounding helpers for the ARGB pixel compositor.
`timescale 1ns / 1ps
package apc_pkg;

  localparam logic [2:0] CMD_OVER_PIXEL = 3'd0;
  localparam logic [2:0] CMD_OVER_SOLID = 3'd1;
  localparam logic [2:0] CMD_MIX        = 3'd2;
  localparam logic [2:0] CMD_OPAC_MASK  = 3'd3;
  localparam logic [2:0] CMD_OPAC_LEVEL = 3'd4;
  localparam logic [2:0] CMD_BRI_MASK   = 3'd5;
  localparam logic [2:0] CMD_BRI_LEVEL  = 3'd6;
  localparam logic [2:0] CMD_FILL       = 3'd7;

  localparam logic [1:0] CFG_SOLID_COLOR  = 2'd0;
  localparam logic [1:0] CFG_ADJUST_LEVEL = 2'd1;

  localparam logic [2:0] LANE_PASS     = 3'd0;
  localparam logic [2:0] LANE_OVER_RGB = 3'd1;
  localparam logic [2:0] LANE_OVER_A   = 3'd2;
  localparam logic [2:0] LANE_MIX      = 3'd3;
  localparam logic [2:0] LANE_SCALE    = 3'd4;

  localparam logic [7:0] CH_MAX    = 8'hFF;
  localparam logic [8:0] LEVEL_ONE = 9'd255;

  typedef logic [2:0] lane_op_t;

  typedef struct packed {
    lane_op_t   op;
    logic [8:0] k;
  } lane_ctrl_t;

  // Exact floor(t / 255) for t below 255 * 257.
  function automatic logic [8:0] div255(input logic [16:0] t);
    logic [17:0] sum;
    sum = {1'b0, t} + {9'd0, t[16:8]} + 18'd1;
    return sum[16:8];
  endfunction

  // Round-to-nearest p / 255.
  function automatic logic [8:0] rnd255(input logic [16:0] p);
    return div255(p + 17'd127);
  endfunction

  function automatic logic [7:0] sat8(input logic [9:0] v);
    return (v > {2'b00, CH_MAX}) ? CH_MAX : v[7:0];
  endfunction

endpackage

// File: rtl/core/apc_in_if.sv
// Input word channel: command, destination, source and mix weight.
`timescale 1ns / 1ps
interface apc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] dest_pixel;
  logic [31:0] source_pixel;
  logic [7:0]  mix_weight;

  modport source (output valid, output command, output dest_pixel,
                  output source_pixel, output mix_weight, input ready);
  modport sink (input valid, input command, input dest_pixel,
                input source_pixel, input mix_weight, output ready);
endinterface

// File: rtl/core/apc_out_if.sv
// Output word channel: result pixel.
`timescale 1ns / 1ps
interface apc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink (input valid, input result_pixel, output ready);
endinterface

// File: rtl/core/apc_lane.sv
// One 8-bit channel datapath: over, mix and level scaling.
`timescale 1ns / 1ps
module apc_lane
  import apc_pkg::*;
(
  input  lane_ctrl_t ctrl,
  input  logic [7:0] d,
  input  logic [7:0] s,
  output logic [7:0] result
);

  logic [7:0]  ax;
  logic [8:0]  ay;
  logic [7:0]  bx;
  logic [8:0]  by;
  logic [16:0] prod_a;
  logic [16:0] prod_b;
  logic [8:0]  rnd_a;
  logic [8:0]  rnd_b;
  logic [8:0]  up_a;
  logic        s_low;
  logic [7:0]  mix_base;
  logic [7:0]  mix_diff;
  logic [7:0]  mix_wt;
  logic        level_up;
  logic [8:0]  mix_sum;

  assign s_low    = (s <= d);
  assign mix_base = s_low ? s : d;
  assign mix_diff = s_low ? (d - s) : (s - d);
  assign mix_wt   = s_low ? ctrl.k[7:0] : (CH_MAX - ctrl.k[7:0]);
  assign level_up = (ctrl.k > LEVEL_ONE);

  always_comb begin
    ax = '0;
    ay = '0;
    bx = '0;
    by = '0;
    case (ctrl.op)
      LANE_OVER_RGB: begin
        ax = d;
        ay = {1'b0, CH_MAX - ctrl.k[7:0]};
        bx = s;
        by = ctrl.k;
      end
      LANE_OVER_A: begin
        ax = CH_MAX - d;
        ay = ctrl.k;
      end
      LANE_MIX: begin
        ax = mix_diff;
        ay = {1'b0, mix_wt};
      end
      LANE_SCALE: begin
        ax = d;
        ay = level_up ? (ctrl.k - LEVEL_ONE) : ctrl.k;
      end
      default: begin
        ax = '0;
      end
    endcase
  end

  assign prod_a = ax * ay;
  assign prod_b = bx * by;
  assign rnd_a  = rnd255(prod_a);
  assign rnd_b  = rnd255(prod_b);
  assign up_a   = 9'((prod_a + 17'd128) >> 8);
  assign mix_sum = {1'b0, mix_base} + rnd_a;

  always_comb begin
    case (ctrl.op)
      LANE_OVER_RGB: result = sat8({1'b0, rnd_a} + {1'b0, rnd_b});
      LANE_OVER_A:   result = sat8({2'b00, d} + {1'b0, rnd_a});
      LANE_MIX:      result = mix_sum[7:0];
      LANE_SCALE: begin
        if (level_up) begin
          result = sat8({2'b00, d} + {1'b0, up_a});
        end else begin
          result = rnd_a[7:0];
        end
      end
      default:       result = d;
    endcase
  end

endmodule

// File: rtl/core/argb_pixel_compositor_top.sv
// Top level of the ARGB pixel compositor: input stage, four lanes, result register.
//
// Usage: each word on req carries a command, a destination pixel, a source or
// mask pixel and a mix weight; one result pixel per word leaves on rsp, in order.
// Both channels use valid/ready; a word moves when both are high at a clock edge.
// Registers solid_color and adjust_level are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no word is in flight, as the block
// itself does not enforce it; there is no read-back.
// Path: a word taken on req is registered in the input stage, computed by four parallel
// 8-bit lanes (two 8x9 multiplies each, then an add-based divide by 255) and registered
// in the result register, which drives rsp. Throughput: one word per cycle while
// rsp.ready is high, set by the single lane pass between the input stage and the
// result register. Stall: when rsp.ready is low the result register holds, the input
// stage still takes one more word, and req.ready drops only once both stages are full.
// Reset: rst (synchronous) empties both stages and sets solid_color to 0 and
// adjust_level to 255.
`timescale 1ns / 1ps
module argb_pixel_compositor_top
  import apc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  apc_in_if.sink       req,
  apc_out_if.source    rsp,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] solid_color;
  logic [8:0]  adjust_level;

  logic        stage_valid;
  logic [2:0]  stage_cmd;
  logic [31:0] stage_dest;
  logic [31:0] stage_src;
  logic [7:0]  stage_weight;

  logic        result_valid;
  logic [31:0] result_pixel;
  logic [31:0] result_pixel_next;

  logic        result_ready;
  logic        stage_ready;

  logic [31:0] src_pix;
  logic [31:0] lane_pix;
  logic [7:0]  src_alpha;
  logic [7:0]  mask_alpha;
  lane_ctrl_t  lane_ctrl [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_color  <= '0;
      adjust_level <= LEVEL_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOLID_COLOR:  solid_color  <= cfg_data;
        CFG_ADJUST_LEVEL: adjust_level <= cfg_data[8:0];
        default: begin
          solid_color <= solid_color;
        end
      endcase
    end
  end

  assign result_ready = !result_valid || rsp.ready;
  assign stage_ready  = !stage_valid || result_ready;
  assign req.ready    = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && req.valid) begin
      stage_cmd    <= req.command;
      stage_dest   <= req.dest_pixel;
      stage_src    <= req.source_pixel;
      stage_weight <= req.mix_weight;
    end
  end

  assign src_pix    = (stage_cmd == CMD_OVER_SOLID) ? solid_color : stage_src;
  assign lane_pix   = (stage_cmd == CMD_FILL) ? solid_color : stage_dest;
  assign src_alpha  = src_pix[31:24];
  assign mask_alpha = stage_src[31:24];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_ctrl[i].op = LANE_PASS;
      lane_ctrl[i].k  = '0;
    end
    case (stage_cmd)
      CMD_OVER_PIXEL, CMD_OVER_SOLID: begin
        if (src_alpha != 8'd0) begin
          for (int i = 0; i < 3; i++) begin
            lane_ctrl[i].op = LANE_OVER_RGB;
            lane_ctrl[i].k  = {1'b0, src_alpha};
          end
          lane_ctrl[3].op = LANE_OVER_A;
          lane_ctrl[3].k  = {1'b0, src_alpha};
        end
      end
      CMD_MIX: begin
        for (int i = 0; i < 4; i++) begin
          lane_ctrl[i].op = LANE_MIX;
          lane_ctrl[i].k  = {1'b0, stage_weight};
        end
      end
      CMD_OPAC_MASK: begin
        lane_ctrl[3].op = LANE_SCALE;
        lane_ctrl[3].k  = {1'b0, mask_alpha};
      end
      CMD_OPAC_LEVEL: begin
        lane_ctrl[3].op = LANE_SCALE;
        lane_ctrl[3].k  = adjust_level;
      end
      CMD_BRI_MASK: begin
        for (int i = 0; i < 3; i++) begin
          lane_ctrl[i].op = LANE_SCALE;
          lane_ctrl[i].k  = {1'b0, mask_alpha};
        end
      end
      CMD_BRI_LEVEL: begin
        for (int i = 0; i < 3; i++) begin
          lane_ctrl[i].op = LANE_SCALE;
          lane_ctrl[i].k  = adjust_level;
        end
      end
      default: begin
        lane_ctrl[0].op = LANE_PASS;
      end
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    apc_lane u_lane (
      .ctrl   (lane_ctrl[g]),
      .d      (lane_pix[8*g +: 8]),
      .s      (src_pix[8*g +: 8]),
      .result (result_pixel_next[8*g +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_ready) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready && stage_valid) begin
      result_pixel <= result_pixel_next;
    end
  end

  assign rsp.valid        = result_valid;
  assign rsp.result_pixel = result_pixel;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stage_valid && !result_valid)
    else $error("pipeline not empty after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !result_ready |=> stage_valid && $stable(stage_dest)
      && $stable(stage_cmd))
    else $error("input stage lost a word under stall");

  a_fill_value: assert property (@(posedge clk) disable iff (rst)
    stage_valid && result_ready && stage_cmd == CMD_FILL
      |=> result_valid && result_pixel == $past(solid_color))
    else $error("fill result differs from solid color");

  a_bri_alpha: assert property (@(posedge clk) disable iff (rst)
    stage_valid && result_ready
      && (stage_cmd == CMD_BRI_MASK || stage_cmd == CMD_BRI_LEVEL)
      |=> result_pixel[31:24] == $past(stage_dest[31:24]))
    else $error("brightness command changed alpha");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid))
    else $error("result appeared without a staged word");

endmodule

// File: bench/tb_argb_pixel_compositor_top.sv
// Testbench for argb_pixel_compositor_top: directed table then random words against a predictor.
`timescale 1ns / 1ps
module tb_argb_pixel_compositor_top
  import apc_pkg::*;
();

  localparam int unsigned FULL    = 255;
  localparam int unsigned FULL_SQ = 255 * 255;
  localparam int unsigned FULL_UP = 255 * 256;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASE_WORDS = 108;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  cmd;
    logic [31:0] dest;
    logic [31:0] src;
    logic [7:0]  weight;
    logic        known;
    logic [31:0] want;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  apc_in_if  pix_in ();
  apc_out_if pix_out ();

  argb_pixel_compositor_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (pix_in),
    .rsp       (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [31:0] fill_color;
  logic [8:0]  level_reg;
  logic [31:0] pixel_queue[$];
  plan_row_t   plan[$];
  int          fault_count;
  int          cycles;
  int          stall_left;
  bit          no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned round_map(input int unsigned n, input int unsigned full,
                                            input int unsigned lo, input int unsigned hi);
    if (lo <= hi) return lo + ((n * (hi - lo) * 2) / full + 1) / 2;
    return hi + (((full - n) * (lo - hi) * 2) / full + 1) / 2;
  endfunction

  function automatic logic [7:0] clip8(input int unsigned v);
    return (v > FULL) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] level_chan(input int unsigned c, input int unsigned lvl);
    if (lvl <= FULL) return 8'(round_map(lvl, FULL, 0, c));
    return clip8(c + round_map(c * (lvl - FULL), FULL_UP, 0, FULL));
  endfunction

  function automatic logic [31:0] blend_over(input logic [31:0] d, input logic [31:0] s);
    int unsigned sa;
    int unsigned da;
    logic [31:0] res;
    sa = s[31:24];
    da = d[31:24];
    if (sa == 0) return d;
    for (int k = 0; k < 3; k++) begin
      res[8*k +: 8] = clip8(round_map(FULL - sa, FULL, 0, d[8*k +: 8]) +
                            round_map(sa, FULL, 0, s[8*k +: 8]));
    end
    res[31:24] = clip8(da + round_map((FULL - da) * sa, FULL_SQ, 0, FULL));
    return res;
  endfunction

  function automatic logic [31:0] predict_pixel(input logic [2:0] cmd, input logic [31:0] d,
                                                input logic [31:0] s, input logic [7:0] w);
    logic [31:0] res;
    int unsigned m;
    m = s[31:24];
    res = d;
    case (cmd)
      CMD_OVER_PIXEL: res = blend_over(d, s);
      CMD_OVER_SOLID: res = blend_over(d, fill_color);
      CMD_MIX: begin
        for (int k = 0; k < 4; k++) begin
          res[8*k +: 8] = 8'(round_map(w, FULL, s[8*k +: 8], d[8*k +: 8]));
        end
      end
      CMD_OPAC_MASK:  res[31:24] = level_chan(d[31:24], m);
      CMD_OPAC_LEVEL: res[31:24] = level_chan(d[31:24], level_reg);
      CMD_BRI_MASK: begin
        for (int k = 0; k < 3; k++) res[8*k +: 8] = level_chan(d[8*k +: 8], m);
      end
      CMD_BRI_LEVEL: begin
        for (int k = 0; k < 3; k++) res[8*k +: 8] = level_chan(d[8*k +: 8], level_reg);
      end
      default: res = fill_color;
    endcase
    return res;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic logic [7:0] pick_chan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] shaped_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 2) != 0) p[31:24] = pick_chan();
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 3) == 0) p[8*k +: 8] = pick_chan();
    end
    return p;
  endfunction

  task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
    fault_count++;
    if (fault_count <= 10) $display("%s: expected %h actual %h", what, want, got);
  endtask

  task automatic add_pred(input logic [2:0] cmd, input logic [31:0] d, input logic [31:0] s,
                          input logic [7:0] w);
    plan.push_back('{ROW_WORD, cmd, d, s, w, 1'b0, 32'd0, 2'd0, 32'd0});
  endtask

  task automatic add_known(input logic [2:0] cmd, input logic [31:0] d, input logic [31:0] s,
                           input logic [7:0] w, input logic [31:0] want);
    plan.push_back('{ROW_WORD, cmd, d, s, w, 1'b1, want, 2'd0, 32'd0});
  endtask

  task automatic add_reg(input logic [1:0] idx, input logic [31:0] val);
    plan.push_back('{ROW_REG, CMD_FILL, 32'd0, 32'd0, 8'd0, 1'b0, 32'd0, idx, val});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    pix_in.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOLID_COLOR) fill_color = val;
    else if (idx == CFG_ADJUST_LEVEL) level_reg = val[8:0];
  endtask

  task automatic send_word(input logic [2:0] cmd, input logic [31:0] d, input logic [31:0] s,
                           input logic [7:0] w, input logic known, input logic [31:0] want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid        <= 1'b1;
    pix_in.command      <= cmd;
    pix_in.dest_pixel   <= d;
    pix_in.source_pixel <= s;
    pix_in.mix_weight   <= w;
    do @(posedge clk); while (!pix_in.ready);
    pixel_queue.push_back(known ? want : predict_pixel(cmd, d, s, w));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pixel_queue.size() == 0) begin
        note_fault("unexpected word", 32'd0, pix_out.result_pixel);
      end else begin
        want = pixel_queue.pop_front();
        if (pix_out.result_pixel !== want) note_fault("result_pixel", want, pix_out.result_pixel);
      end
    end
  end

  initial begin
    plan_row_t   row;
    logic [31:0] sc;
    logic [8:0]  lv;
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    pix_in.valid        = 1'b0;
    pix_in.command      = CMD_OVER_PIXEL;
    pix_in.dest_pixel   = '0;
    pix_in.source_pixel = '0;
    pix_in.mix_weight   = '0;
    fill_color          = 32'd0;
    level_reg           = LEVEL_ONE;
    fault_count         = 0;
    cycles              = 0;
    stall_left          = 0;
    no_idle             = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_known(CMD_FILL,       32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'h00000000);
    add_known(CMD_OVER_SOLID, 32'h12345678, 32'hFFFFFFFF, 8'h00, 32'h12345678);
    add_known(CMD_OPAC_LEVEL, 32'h89ABCDEF, 32'h00000000, 8'h00, 32'h89ABCDEF);
    add_known(CMD_BRI_LEVEL,  32'h89ABCDEF, 32'h00000000, 8'h00, 32'h89ABCDEF);
    // transparent source leaves dest untouched
    add_known(CMD_OVER_PIXEL, 32'hA1B2C3D4, 32'h00FFFFFF, 8'h55, 32'hA1B2C3D4);
    add_known(CMD_OVER_PIXEL, 32'h00000000, 32'hFF102030, 8'h00, 32'hFF102030);
    add_known(CMD_OVER_PIXEL, 32'hFFFFFFFF, 32'hFF000000, 8'h00, 32'hFF000000);
    add_pred(CMD_OVER_PIXEL,  32'hFFFFFFFF, 32'h80FFFFFF, 8'h00);
    add_pred(CMD_OVER_PIXEL,  32'h40FEFDFC, 32'h81FBFEFD, 8'h00);
    add_known(CMD_MIX,        32'h11223344, 32'hAABBCCDD, 8'hFF, 32'h11223344);
    add_known(CMD_MIX,        32'h11223344, 32'hAABBCCDD, 8'h00, 32'hAABBCCDD);
    add_pred(CMD_MIX,         32'hFF00FF00, 32'h00FF00FF, 8'h80);
    add_known(CMD_OPAC_MASK,  32'hFFABCDEF, 32'h00123456, 8'h00, 32'h00ABCDEF);
    add_known(CMD_OPAC_MASK,  32'h3CABCDEF, 32'hFF000000, 8'h00, 32'h3CABCDEF);
    add_pred(CMD_OPAC_MASK,   32'hC8ABCDEF, 32'h40FFFFFF, 8'h00);
    add_known(CMD_BRI_MASK,   32'h7F102030, 32'h00FFFFFF, 8'h00, 32'h7F000000);
    add_known(CMD_BRI_MASK,   32'h7F102030, 32'hFF000000, 8'h00, 32'h7F102030);
    add_pred(CMD_BRI_MASK,    32'h80FFFFFF, 32'h80123456, 8'h00);
    add_reg(CFG_SOLID_COLOR,  32'h80FF8000);
    add_reg(CFG_ADJUST_LEVEL, 32'd511);
    add_pred(CMD_OVER_SOLID,  32'h00000000, 32'h00000000, 8'h00);
    add_pred(CMD_OPAC_LEVEL,  32'h80FFFFFF, 32'h00000000, 8'h00);
    add_pred(CMD_BRI_LEVEL,   32'h12406080, 32'h00000000, 8'h00);
    add_known(CMD_FILL,       32'h00000000, 32'h00000000, 8'h00, 32'h80FF8000);
    add_reg(CFG_SOLID_COLOR,  32'hFFFFFFFF);
    add_reg(CFG_ADJUST_LEVEL, 32'd0);
    add_known(CMD_OPAC_LEVEL, 32'hC0123456, 32'h00000000, 8'h00, 32'h00123456);
    add_known(CMD_BRI_LEVEL,  32'hC0123456, 32'h00000000, 8'h00, 32'hC0000000);
    add_known(CMD_OVER_SOLID, 32'h12345678, 32'h00000000, 8'h00, 32'hFFFFFFFF);
    add_known(CMD_FILL,       32'h12345678, 32'h00000000, 8'h00, 32'hFFFFFFFF);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) write_reg(row.reg_idx, row.reg_val);
      else send_word(row.cmd, row.dest, row.src, row.weight, row.known, row.want);
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin sc = 32'h00000000;              lv = 9'd256; end
        1: begin sc = 32'hFFFFFFFF;              lv = 9'd511; end
        2: begin sc = {8'h00, 24'($urandom)};    lv = 9'd0;   end
        3: begin sc = $urandom;                  lv = 9'($urandom_range(0, 511)); end
        default: begin sc = shaped_pixel();      lv = LEVEL_ONE; end
      endcase
      write_reg(CFG_SOLID_COLOR, sc);
      write_reg(CFG_ADJUST_LEVEL, {23'd0, lv});
      no_idle = (phase == 2);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(3'($urandom_range(0, 7)), shaped_pixel(), shaped_pixel(),
                  ($urandom_range(0, 3) == 0) ? pick_chan() : 8'($urandom), 1'b0, 32'd0);
      end
      no_idle = 1'b0;
    end

    pix_in.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pixel_queue.size() != 0) note_fault("missing word", pixel_queue[0], 32'd0);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
